// ----- hdl/srld_pkg.sv -----
// Shared types and constants for the sprite row run-length decoder.
// Used by srld_queue, srld_exec and the top level; no dependencies.
package srld_pkg;

   localparam int MAX_DIM_DEFAULT = 1024;
   localparam int QUEUE_DEPTH     = 2;
   localparam int ABORT_SUM       = 2048;
   localparam int DIM_W           = 10;
   localparam int WORD_W          = 16;
   localparam int RUN_W           = 11;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ABORT   = 2'd2,
      KIND_OUTSIDE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_SKIP  = 2'd0,
      PHASE_RUN   = 2'd1,
      PHASE_COLOR = 2'd2
   } phase_type;

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] data_word;
   } req_payload_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] pixel_x;
      logic [DIM_W-1:0]  pixel_y;
      logic [WORD_W-1:0] pixel_color;
   } rsp_payload_type;

   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] word;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

endpackage

// ----- hdl/srld_queue.sv -----
// Front end: accepts requests, classifies them as start or data, and holds
// them in a short queue for the back end. Depends on srld_pkg.
module srld_queue #(
   parameter int DEPTH = srld_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  srld_pkg::req_payload_type req_payload,
   output srld_pkg::queue_head_type head,
   input  logic                     head_pop
);
   import srld_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;
   queue_item_type    item_in;

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = head_pop && (count_ff != '0);

   always_comb begin
      item_in.op   = req_payload.command ? OP_START : OP_DATA;
      item_in.word = req_payload.data_word;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = entry_ff[rd_ptr_ff];
   end

endmodule

// ----- hdl/srld_exec.sv -----
// Back end: walks the row stream state machine and drives the result register.
// Depends on srld_pkg; fed by srld_queue.
module srld_exec #(
   parameter int MAX_DIM = srld_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  srld_pkg::queue_head_type         head,
   output logic                             head_pop,
   input  logic [srld_pkg::DIM_W-1:0]       image_width,
   input  logic [srld_pkg::DIM_W-1:0]       image_height,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output srld_pkg::rsp_payload_type        rsp_payload
);
   import srld_pkg::*;

   localparam int LIMIT = MAX_DIM - 1;

   phase_type          phase_ff, phase_in;
   logic [WORD_W-1:0]  skip_ff, skip_in;
   logic [RUN_W-1:0]   run_left_ff, run_left_in;
   logic [WORD_W-1:0]  column_ff, column_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic               finished_ff, finished_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic [DIM_W-1:0]   width_lim;
   logic [DIM_W-1:0]   height_lim;
   logic [WORD_W:0]    pair_sum;
   logic [WORD_W:0]    skip_sum;
   logic [WORD_W:0]    step_sum;
   logic [DIM_W-1:0]   row_next;
   logic [RUN_W-1:0]   run_dec;
   logic               take;

   assign width_lim  = (32'(image_width) > 32'(LIMIT)) ? DIM_W'(LIMIT) : image_width;
   assign height_lim = (32'(image_height) > 32'(LIMIT)) ? DIM_W'(LIMIT) : image_height;
   assign pair_sum   = {1'b0, skip_ff} + {1'b0, head.item.word};
   assign skip_sum   = {1'b0, column_ff} + {1'b0, skip_ff};
   assign step_sum   = {1'b0, column_ff} + (WORD_W + 1)'(1);
   assign row_next   = row_ff + 1'b1;
   assign run_dec    = run_left_ff - 1'b1;

   assign take      = head.valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop  = take;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      phase_in       = phase_ff;
      skip_in        = skip_ff;
      run_left_in    = run_left_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      finished_in    = finished_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (take) begin
         if (head.item.op == OP_START) begin
            phase_in    = PHASE_SKIP;
            skip_in     = '0;
            run_left_in = '0;
            column_in   = '0;
            row_in      = '0;
            finished_in = 1'b0;
         end else if (!finished_ff) begin
            case (phase_ff)
               PHASE_RUN: begin
                  if (pair_sum >= (WORD_W + 1)'(ABORT_SUM)) begin
                     finished_in         = 1'b1;
                     phase_in            = PHASE_SKIP;
                     rsp_valid_in        = 1'b1;
                     rsp_payload_in      = '0;
                     rsp_payload_in.kind = KIND_ABORT;
                  end else if (pair_sum == '0) begin
                     column_in = '0;
                     row_in    = row_next;
                     phase_in  = PHASE_SKIP;
                     if (row_next >= height_lim || row_next == '0) begin
                        finished_in         = 1'b1;
                        rsp_valid_in        = 1'b1;
                        rsp_payload_in      = '0;
                        rsp_payload_in.kind = KIND_DONE;
                     end
                  end else begin
                     column_in   = skip_sum[WORD_W] ? '1 : skip_sum[WORD_W-1:0];
                     run_left_in = head.item.word[RUN_W-1:0];
                     phase_in    = (head.item.word[RUN_W-1:0] == '0) ? PHASE_SKIP
                                                                     : PHASE_COLOR;
                  end
               end
               PHASE_COLOR: begin
                  rsp_valid_in = 1'b1;
                  rsp_payload_in.kind = (column_ff >= WORD_W'(width_lim)) ? KIND_OUTSIDE
                                                                          : KIND_PIXEL;
                  rsp_payload_in.pixel_x     = column_ff;
                  rsp_payload_in.pixel_y     = row_ff;
                  rsp_payload_in.pixel_color = head.item.word;
                  column_in   = step_sum[WORD_W] ? '1 : step_sum[WORD_W-1:0];
                  run_left_in = run_dec;
                  if (run_dec == '0) begin
                     phase_in = PHASE_SKIP;
                  end
               end
               default: begin
                  skip_in  = head.item.word;
                  phase_in = PHASE_RUN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_SKIP;
         skip_ff      <= '0;
         run_left_ff  <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         run_left_ff  <= run_left_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ----- hdl/sprite_row_run_length_decoder_top.sv -----
// An accepted request is stored in the queue; any result it yields is then registered in the result register.
// Throughput: one request per cycle while no result is held back by rsp_ready; the
// two-entry request queue keeps accepting input while a result waits, until it fills.
// Reset (synchronous, active high) empties the queue and result register,
// clears position and status, and sets width and height to 44.
// Top level of the sprite row run-length decoder; depends on srld_pkg.
module sprite_row_run_length_decoder_top #(
   parameter int MAX_DIM = srld_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  srld_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output srld_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_write_en,
   input  logic [srld_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srld_pkg::DIM_W-1:0]        csr_write_data
);
   import srld_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   queue_head_type   head;
   logic             head_pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(44);
         height_ff <= DIM_W'(44);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   srld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head        (head),
      .head_pop    (head_pop)
   );

   srld_exec #(
      .MAX_DIM (MAX_DIM)
   ) u_exec (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_pop     (head_pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule
